>>> design/yrab_pkg.sv
// ----------------------------------------------------------------------------
// yrab_pkg
// Shared types and fixed-point constants for the YUV to RGB alpha blender.
// ----------------------------------------------------------------------------
`default_nettype none

package yrab_pkg;

    localparam int PIX_W       = 8;
    localparam int SCALE_BITS  = 10;
    localparam int ALPHA_SHIFT = 8;
    localparam int SUM_W       = 22;  // signed width of the products and sums
    localparam int PROD_W      = 2 * PIX_W;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = PIX_W'(255);
    localparam logic [PIX_W-1:0] PIX_MAX      = PIX_W'(255);

    // 10-bit fixed-point studio-to-full-range coefficients
    localparam logic signed [SUM_W-1:0] COEF_Y   = SUM_W'(1192);
    localparam logic signed [SUM_W-1:0] COEF_RV  = SUM_W'(1634);
    localparam logic signed [SUM_W-1:0] COEF_GU  = SUM_W'(401);
    localparam logic signed [SUM_W-1:0] COEF_GV  = SUM_W'(832);
    localparam logic signed [SUM_W-1:0] COEF_BU  = SUM_W'(2066);
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1 << (SCALE_BITS - 1));

    localparam logic signed [PIX_W+1:0] LUMA_OFS   = (PIX_W + 2)'(16);
    localparam logic signed [PIX_W:0]   CHROMA_OFS = (PIX_W + 1)'(128);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    // converted overlay pixel plus what the blend still needs
    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        rgb_t             conv;
        rgb_t             under;
    } blend_in_t;

endpackage

`default_nettype wire

>>> design/yuv_to_rgb_alpha_blend_top.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_alpha_blend_top
// Converts one studio-range YCbCr overlay pixel to RGB and blends it over
// the underlying RGB pixel by an 8-bit alpha.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid / in_ready | src_luma src_cb src_cr alpha
//           |                     | under_red under_green under_blue
//   out     | out_valid/out_ready | out_red out_green out_blue write_pixel
//
// Four register stages: products, sum/clamp, blend products, output register.
// An input transaction reaches out_valid after passing through all stage
// registers in order; one pixel per clock is sustained while out_ready
// stays high.
// A stall at the output backs up stage by stage through per-stage valid bits,
// so bubbles are squeezed out and nothing is dropped or repeated.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_to_rgb_alpha_blend_top
    import yrab_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic [PIX_W-1:0] src_luma,
    input  wire logic [PIX_W-1:0] src_cb,
    input  wire logic [PIX_W-1:0] src_cr,
    input  wire logic [PIX_W-1:0] alpha,
    input  wire logic [PIX_W-1:0] under_red,
    input  wire logic [PIX_W-1:0] under_green,
    input  wire logic [PIX_W-1:0] under_blue,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic [PIX_W-1:0] out_red,
    output      logic [PIX_W-1:0] out_green,
    output      logic [PIX_W-1:0] out_blue,
    output      logic             write_pixel
);

    rgb_t      under;
    rgb_t      pixel;
    blend_in_t conv_data;
    logic      conv_valid;
    logic      blend_ready;

    assign under = '{red: under_red, green: under_green, blue: under_blue};

    yrab_convert u_convert (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_luma   (src_luma),
        .in_cb     (src_cb),
        .in_cr     (src_cr),
        .in_alpha  (alpha),
        .in_under  (under),
        .out_valid (conv_valid),
        .out_ready (blend_ready),
        .out_data  (conv_data)
    );

    yrab_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (conv_valid),
        .in_ready  (blend_ready),
        .in_data   (conv_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (pixel),
        .out_write (write_pixel)
    );

    assign out_red   = pixel.red;
    assign out_green = pixel.green;
    assign out_blue  = pixel.blue;

endmodule

`default_nettype wire

>>> design/yrab_convert.sv
// ----------------------------------------------------------------------------
// yrab_convert
// Two-stage YCbCr to RGB conversion: coefficient products, then sum,
// rounding, shift and clamp to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module yrab_convert
    import yrab_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic [PIX_W-1:0] in_luma,
    input  wire logic [PIX_W-1:0] in_cb,
    input  wire logic [PIX_W-1:0] in_cr,
    input  wire logic [PIX_W-1:0] in_alpha,
    input  wire rgb_t             in_under,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      blend_in_t        out_data
);

    // stage 1: products
    logic                    s1_valid_reg;
    logic signed [SUM_W-1:0] s1_ys_reg;
    logic signed [SUM_W-1:0] s1_rv_reg;
    logic signed [SUM_W-1:0] s1_gu_reg;
    logic signed [SUM_W-1:0] s1_gv_reg;
    logic signed [SUM_W-1:0] s1_bu_reg;
    logic [PIX_W-1:0]        s1_alpha_reg;
    rgb_t                    s1_under_reg;

    // stage 2: clamped colour
    logic                    s2_valid_reg;
    blend_in_t               s2_data_reg;

    logic                    s1_ready;
    logic                    s2_ready;

    logic signed [PIX_W+1:0] luma_off;
    logic signed [PIX_W:0]   cb_off;
    logic signed [PIX_W:0]   cr_off;
    logic signed [SUM_W-1:0] ys_next;
    logic signed [SUM_W-1:0] rv_next;
    logic signed [SUM_W-1:0] gu_next;
    logic signed [SUM_W-1:0] gv_next;
    logic signed [SUM_W-1:0] bu_next;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] g_sum;
    logic signed [SUM_W-1:0] b_sum;
    blend_in_t               s2_data_next;

    function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] sum);
        logic [SUM_W-SCALE_BITS-1:0] whole;
        logic [PIX_W-1:0]            res;
        whole = sum[SUM_W-1:SCALE_BITS];
        if (sum[SUM_W-1])
            res = '0;
        else if (whole > (SUM_W - SCALE_BITS)'(PIX_MAX))
            res = PIX_MAX;
        else
            res = whole[PIX_W-1:0];
        return res;
    endfunction

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        luma_off = $signed({2'b00, in_luma}) - LUMA_OFS;
        cb_off   = $signed({1'b0, in_cb}) - CHROMA_OFS;
        cr_off   = $signed({1'b0, in_cr}) - CHROMA_OFS;
        ys_next  = SUM_W'(luma_off) * COEF_Y;
        rv_next  = SUM_W'(cr_off) * COEF_RV;
        gu_next  = SUM_W'(cb_off) * COEF_GU;
        gv_next  = SUM_W'(cr_off) * COEF_GV;
        bu_next  = SUM_W'(cb_off) * COEF_BU;
    end

    always_comb
    begin
        r_sum = s1_ys_reg + s1_rv_reg + HALF_LSB;
        g_sum = s1_ys_reg - s1_gu_reg - s1_gv_reg + HALF_LSB;
        b_sum = s1_ys_reg + s1_bu_reg + HALF_LSB;
        s2_data_next.alpha      = s1_alpha_reg;
        s2_data_next.under      = s1_under_reg;
        s2_data_next.conv.red   = clamp_pix(r_sum);
        s2_data_next.conv.green = clamp_pix(g_sum);
        s2_data_next.conv.blue  = clamp_pix(b_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_ys_reg    <= ys_next;
            s1_rv_reg    <= rv_next;
            s1_gu_reg    <= gu_next;
            s1_gv_reg    <= gv_next;
            s1_bu_reg    <= bu_next;
            s1_alpha_reg <= in_alpha;
            s1_under_reg <= in_under;
        end
        if (s1_valid_reg && s2_ready)
            s2_data_reg <= s2_data_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

`default_nettype wire

>>> design/yrab_blend.sv
// ----------------------------------------------------------------------------
// yrab_blend
// Two-stage alpha blend: per-channel weight products, then sum, shift and
// the transparent / opaque selection into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module yrab_blend
    import yrab_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire blend_in_t        in_data,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      rgb_t             out_pixel,
    output      logic             out_write
);

    // stage 3: weight products
    logic                    s3_valid_reg;
    logic [2:0][PROD_W-1:0]  s3_pc_reg;
    logic [2:0][PROD_W-1:0]  s3_po_reg;
    blend_in_t               s3_data_reg;

    // stage 4: output register
    logic                    s4_valid_reg;
    rgb_t                    s4_pixel_reg;
    logic                    s4_write_reg;

    logic                    s3_ready;
    logic                    s4_ready;

    logic [PIX_W-1:0]        alpha_inv;
    logic [2:0][PIX_W-1:0]   conv_ch;
    logic [2:0][PIX_W-1:0]   under_ch;
    logic [2:0][PROD_W-1:0]  pc_next;
    logic [2:0][PROD_W-1:0]  po_next;
    logic [2:0][PROD_W:0]    mix_sum;
    logic [2:0][PIX_W-1:0]   mix_ch;
    rgb_t                    pixel_next;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    always_comb
    begin
        alpha_inv = ALPHA_OPAQUE - in_data.alpha;
        conv_ch   = {in_data.conv.red, in_data.conv.green, in_data.conv.blue};
        under_ch  = {in_data.under.red, in_data.under.green, in_data.under.blue};
        for (int i = 0; i < 3; i++)
        begin
            pc_next[i] = PROD_W'(conv_ch[i]) * PROD_W'(in_data.alpha);
            po_next[i] = PROD_W'(under_ch[i]) * PROD_W'(alpha_inv);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mix_sum[i] = (PROD_W + 1)'(s3_pc_reg[i]) + (PROD_W + 1)'(s3_po_reg[i]);
            // blend never exceeds 254, so bits 15:8 of the sum suffice
            mix_ch[i]  = mix_sum[i][ALPHA_SHIFT +: PIX_W];
        end
        if (s3_data_reg.alpha == '0)
            pixel_next = s3_data_reg.under;
        else if (s3_data_reg.alpha == ALPHA_OPAQUE)
            pixel_next = s3_data_reg.conv;
        else
            pixel_next = {mix_ch[2], mix_ch[1], mix_ch[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= in_valid;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s3_ready)
        begin
            s3_pc_reg   <= pc_next;
            s3_po_reg   <= po_next;
            s3_data_reg <= in_data;
        end
        if (s3_valid_reg && s4_ready)
        begin
            s4_pixel_reg <= pixel_next;
            s4_write_reg <= (s3_data_reg.alpha != '0);
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_pixel = s4_pixel_reg;
    assign out_write = s4_write_reg;

endmodule

`default_nettype wire

>>> design/yrab_checker.sv
// ----------------------------------------------------------------------------
// yrab_checker
// Port-level checks on the blender: output hold, pass-through of
// transparent pixels, write flag and fixed latency under free flow.
// ----------------------------------------------------------------------------
`default_nettype none

module yrab_checker
    import yrab_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic [PIX_W-1:0] alpha,
    input wire logic [PIX_W-1:0] under_red,
    input wire logic [PIX_W-1:0] under_green,
    input wire logic [PIX_W-1:0] under_blue,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [PIX_W-1:0] out_red,
    input wire logic [PIX_W-1:0] out_green,
    input wire logic [PIX_W-1:0] out_blue,
    input wire logic             write_pixel
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red)
            && $stable(out_green) && $stable(out_blue) && $stable(write_pixel))
        else $error("output changed while stalled");

    // with the output draining every cycle, an accepted transaction reaches out_valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
            |=> out_valid)
        else $error("pipeline lost a transaction");

    // transparent pixel passes the underlay through without a write
    a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready && alpha == '0)
            ##1 out_ready ##1 out_ready ##1 out_ready
            |=> !write_pixel && out_red == $past(under_red, 4)
                && out_green == $past(under_green, 4) && out_blue == $past(under_blue, 4))
        else $error("transparent pixel altered");

    // any visible overlay pixel is written
    a_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready && alpha != '0)
            ##1 out_ready ##1 out_ready ##1 out_ready
            |=> write_pixel)
        else $error("write flag missing");

endmodule

bind yuv_to_rgb_alpha_blend_top yrab_checker u_yrab_checker (.*);

`default_nettype wire
